### rtl/psl_pkg.sv
// Package: command codes, item and result types of the packet sequence loss counter.
`default_nettype none
package psl_pkg;

	localparam logic [1:0] CMD_PACKET = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_STOP   = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        header_ok;
		logic [31:0] magic_word;
		logic [31:0] sequence_number;
		logic [15:0] packet_length;
	} item_t;

	typedef struct packed {
		logic        running;
		logic [31:0] packet_count;
		logic [31:0] byte_count;
		logic [31:0] lost_count;
		logic [31:0] reorder_count;
		logic [31:0] invalid_count;
		logic [31:0] tick_count;
	} result_t;

endpackage
`default_nettype wire

### rtl/psl_if.sv
// Interfaces: packet input, result output and magic register write channels.
`default_nettype none
interface psl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        header_ok;
	logic [31:0] magic_word;
	logic [31:0] sequence_number;
	logic [15:0] packet_length;

	modport source (output valid, cmd, header_ok, magic_word, sequence_number,
		packet_length, input ready);
	modport sink (input valid, cmd, header_ok, magic_word, sequence_number,
		packet_length, output ready);
endinterface

interface psl_out_if;
	logic        valid;
	logic        ready;
	logic        running;
	logic [31:0] packet_count;
	logic [31:0] byte_count;
	logic [31:0] lost_count;
	logic [31:0] reorder_count;
	logic [31:0] invalid_count;
	logic [31:0] tick_count;

	modport source (output valid, running, packet_count, byte_count, lost_count,
		reorder_count, invalid_count, tick_count, input ready);
	modport sink (input valid, running, packet_count, byte_count, lost_count,
		reorder_count, invalid_count, tick_count, output ready);
endinterface

interface psl_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/psl_core.sv
// Counter state and the single-pass update for one command transaction.
`default_nettype none
module psl_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire psl_pkg::item_t  item,
	input  wire logic [31:0]     magic,
	output psl_pkg::result_t     nxt
);

	logic        armed_q;
	logic        exp_valid_q;
	logic [31:0] exp_seq_q;
	logic [31:0] pkts_q;
	logic [31:0] bytes_q;
	logic [31:0] gaps_q;
	logic [31:0] late_q;
	logic [31:0] bad_q;
	logic [31:0] ticks_q;

	logic        exp_valid_d;
	logic [31:0] exp_seq_d;
	logic [31:0] diff;
	logic        good;

	assign diff = item.sequence_number - exp_seq_q;
	assign good = item.header_ok && (item.magic_word == magic);

	always_comb begin
		nxt.running       = armed_q;
		nxt.packet_count  = pkts_q;
		nxt.byte_count    = bytes_q;
		nxt.lost_count    = gaps_q;
		nxt.reorder_count = late_q;
		nxt.invalid_count = bad_q;
		nxt.tick_count    = ticks_q;
		exp_valid_d       = exp_valid_q;
		exp_seq_d         = exp_seq_q;
		case (item.cmd)
			psl_pkg::CMD_START: begin
				nxt         = '0;
				nxt.running = 1'b1;
				exp_valid_d = 1'b0;
				exp_seq_d   = '0;
			end
			psl_pkg::CMD_STOP: begin
				nxt.running = 1'b0;
			end
			psl_pkg::CMD_TICK: begin
				if (armed_q)
					nxt.tick_count = ticks_q + 32'd1;
			end
			default: begin
				if (armed_q) begin
					if (!good) begin
						nxt.invalid_count = bad_q + 32'd1;
					end else begin
						nxt.packet_count = pkts_q + 32'd1;
						nxt.byte_count   = bytes_q + {16'd0, item.packet_length};
						// exact match gives diff 0: same as a zero-length gap
						if (!exp_valid_q) begin
							exp_valid_d = 1'b1;
							exp_seq_d   = item.sequence_number + 32'd1;
						end else if (!diff[31]) begin
							nxt.lost_count = gaps_q + diff;
							exp_seq_d      = item.sequence_number + 32'd1;
						end else begin
							nxt.reorder_count = late_q + 32'd1;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			exp_valid_q <= 1'b0;
			exp_seq_q   <= '0;
			pkts_q      <= '0;
			bytes_q     <= '0;
			gaps_q      <= '0;
			late_q      <= '0;
			bad_q       <= '0;
			ticks_q     <= '0;
		end else if (step) begin
			armed_q     <= nxt.running;
			exp_valid_q <= exp_valid_d;
			exp_seq_q   <= exp_seq_d;
			pkts_q      <= nxt.packet_count;
			bytes_q     <= nxt.byte_count;
			gaps_q      <= nxt.lost_count;
			late_q      <= nxt.reorder_count;
			bad_q       <= nxt.invalid_count;
			ticks_q     <= nxt.tick_count;
		end
	end

endmodule
`default_nettype wire

### rtl/packet_sequence_loss_counter.sv
// Top level: input register, counter core, result register and magic register.
// Packet sequence loss counter. Each input transaction carries one command
// (packet header, start, stop or time tick) and yields exactly one result
// transaction holding every counter after that command. Throughput is one
// transaction per cycle while the result side is not stalled; the input
// register is loaded when the input is accepted, and the counter update
// then writes the result register, which offers the result. All counter
// arithmetic is 32-bit add, subtract or compare between the input register
// and the counters, so the next command already sees the updated state. A
// stalled result register holds the input register, and the input side then
// accepts no further transaction until the result is taken. The magic word
// register resets to zero and must only be written while no transaction is
// in flight.
`default_nettype none
module packet_sequence_loss_counter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	psl_in_if.sink     pkt_in,
	psl_out_if.source  res_out,
	psl_cfg_if.sink    cfg
);

	psl_pkg::item_t   item_s1;
	logic             valid_s1;
	psl_pkg::result_t res_q;
	logic             out_valid_q;
	logic [31:0]      magic_q;
	psl_pkg::result_t nxt;
	logic             step;

	// core advances when the input register holds an item and the result register is free or being emptied
	assign step         = valid_s1 && (!out_valid_q || res_out.ready);
	assign pkt_in.ready = !valid_s1 || step;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			magic_q <= '0;
		else if (cfg.valid)
			magic_q <= cfg.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pkt_in.ready)
			valid_s1 <= pkt_in.valid;
	end

	always_ff @(posedge clk) begin
		if (pkt_in.valid && pkt_in.ready) begin
			item_s1.cmd             <= pkt_in.cmd;
			item_s1.header_ok       <= pkt_in.header_ok;
			item_s1.magic_word      <= pkt_in.magic_word;
			item_s1.sequence_number <= pkt_in.sequence_number;
			item_s1.packet_length   <= pkt_in.packet_length;
		end
	end

	psl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.magic  (magic_q),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= 1'b1;
		else if (res_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= nxt;
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.running       = res_q.running;
	assign res_out.packet_count  = res_q.packet_count;
	assign res_out.byte_count    = res_q.byte_count;
	assign res_out.lost_count    = res_q.lost_count;
	assign res_out.reorder_count = res_q.reorder_count;
	assign res_out.invalid_count = res_q.invalid_count;
	assign res_out.tick_count    = res_q.tick_count;

`ifndef SYNTH
	// start yields an armed result with the packet, lost and tick counters cleared
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.cmd == psl_pkg::CMD_START) |=>
		(res_q.running && res_q.packet_count == '0 && res_q.lost_count == '0
		&& res_q.tick_count == '0))
		else $error("start did not clear counters");

	// stop yields a disarmed result
	a_stop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.cmd == psl_pkg::CMD_STOP) |=> !res_q.running)
		else $error("stop did not disarm");

	// input back-pressure only when both stages are full and the output stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt_in.ready |-> (valid_s1 && out_valid_q && !res_out.ready))
		else $error("input stalled without cause");

	// a new result appears only after the core advanced
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step))
		else $error("result without core step");
`endif

endmodule
`default_nettype wire

### verif/psl_scoreboard_pkg.sv
// Scoreboard class for the packet sequence loss counter: counter prediction and result checks.
`default_nettype none
package psl_scoreboard_pkg;
	import psl_pkg::*;

	class psl_scoreboard;
		bit [31:0] magic;
		bit        armed;
		bit        seq_known;
		bit [31:0] next_seq;
		bit [31:0] packets;
		bit [31:0] bytes;
		bit [31:0] lost;
		bit [31:0] late;
		bit [31:0] bad;
		bit [31:0] ticks;
		result_t   counters_q[$];
		int unsigned items_noted;
		int unsigned results_checked;
		int unsigned mismatches;

		function new();
			magic = '0;
			armed = 1'b0;
			clear_counters();
		endfunction

		function void clear_counters();
			seq_known = 1'b0;
			next_seq = '0;
			packets = '0;
			bytes = '0;
			lost = '0;
			late = '0;
			bad = '0;
			ticks = '0;
		endfunction

		function void set_magic(bit [31:0] value);
			magic = value;
		endfunction

		function int unsigned pending();
			return counters_q.size();
		endfunction

		// Update the counters for one accepted command and queue the counter snapshot.
		function void note_item(item_t it);
			result_t   want;
			bit [31:0] diff;
			items_noted++;
			case (it.cmd)
				CMD_START: begin
					clear_counters();
					armed = 1'b1;
				end
				CMD_STOP: armed = 1'b0;
				CMD_TICK: if (armed) ticks++;
				default: if (armed) begin
					if (!it.header_ok || it.magic_word != magic) begin
						bad++;
					end else begin
						if (!seq_known) begin
							seq_known = 1'b1;
							next_seq = it.sequence_number + 32'd1;
						end else if (it.sequence_number == next_seq) begin
							next_seq++;
						end else begin
							diff = it.sequence_number - next_seq;
							// forward jump: skipped numbers count as lost, then resync
							if (!diff[31]) begin
								lost += diff;
								next_seq = it.sequence_number + 32'd1;
							end else begin
								late++;
							end
						end
						packets++;
						bytes += 32'(it.packet_length);
					end
				end
			endcase
			want.running = armed;
			want.packet_count = packets;
			want.byte_count = bytes;
			want.lost_count = lost;
			want.reorder_count = late;
			want.invalid_count = bad;
			want.tick_count = ticks;
			counters_q.push_back(want);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s: expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_checked++;
			if (counters_q.size() == 0) begin
				flag("result with nothing outstanding", 'x, got.packet_count);
				return;
			end
			want = counters_q.pop_front();
			if (got.running !== want.running)
				flag("running", 32'(want.running), 32'(got.running));
			if (got.packet_count !== want.packet_count)
				flag("packet_count", want.packet_count, got.packet_count);
			if (got.byte_count !== want.byte_count)
				flag("byte_count", want.byte_count, got.byte_count);
			if (got.lost_count !== want.lost_count)
				flag("lost_count", want.lost_count, got.lost_count);
			if (got.reorder_count !== want.reorder_count)
				flag("reorder_count", want.reorder_count, got.reorder_count);
			if (got.invalid_count !== want.invalid_count)
				flag("invalid_count", want.invalid_count, got.invalid_count);
			if (got.tick_count !== want.tick_count)
				flag("tick_count", want.tick_count, got.tick_count);
		endfunction

		function void flush_leftover();
			while (counters_q.size() != 0) begin
				flag("result never arrived", counters_q[0].packet_count, 'x);
				void'(counters_q.pop_front());
			end
		endfunction
	endclass

endpackage
`default_nettype wire

### verif/packet_sequence_loss_counter_test.sv
// Testbench top: directed and random command streams through the packet sequence loss counter.
`default_nettype none
module packet_sequence_loss_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import psl_pkg::*;
	import psl_scoreboard_pkg::*;

	// No transaction on any channel for this many cycles means the block is stuck.
	// The longest legal quiet stretch is the receiver hold-off below.
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	logic clk;
	logic arst_n;

	psl_in_if  pkt_in();
	psl_out_if res_out();
	psl_cfg_if cfg();

	packet_sequence_loss_counter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt_in  (pkt_in),
		.res_out (res_out),
		.cfg     (cfg)
	);

	psl_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_cycles;
	int unsigned magic_writes;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random back-pressure, plus one long hold-off on request so the
	// result register and then the input register fill and the input stalls.
	initial begin
		res_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				res_out.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			res_out.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result monitor: every transaction on the output channel is checked.
	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && res_out.valid && res_out.ready) begin
			got.running = res_out.running;
			got.packet_count = res_out.packet_count;
			got.byte_count = res_out.byte_count;
			got.lost_count = res_out.lost_count;
			got.reorder_count = res_out.reorder_count;
			got.invalid_count = res_out.invalid_count;
			got.tick_count = res_out.tick_count;
			sb.check_result(got);
		end
	end

	// Watchdog: counts cycles without any transaction after reset release.
	always @(posedge clk) begin
		if (!arst_n || (pkt_in.valid && pkt_in.ready) || (res_out.valid && res_out.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_item(logic [1:0] cmd, logic hdr, logic [31:0] magic,
			logic [31:0] seq, logic [15:0] len);
		item_t it;
		it.cmd = cmd;
		it.header_ok = hdr;
		it.magic_word = magic;
		it.sequence_number = seq;
		it.packet_length = len;
		return it;
	endfunction

	// Offer one transaction, idling first at the sender's rate; the
	// prediction is updated at the edge where it is accepted.
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			pkt_in.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_in.valid <= 1'b1;
		pkt_in.cmd <= it.cmd;
		pkt_in.header_ok <= it.header_ok;
		pkt_in.magic_word <= it.magic_word;
		pkt_in.sequence_number <= it.sequence_number;
		pkt_in.packet_length <= it.packet_length;
		@(posedge clk);
		while (!pkt_in.ready) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic send_packet(input logic [31:0] seq, input logic [15:0] len);
		send_item(make_item(CMD_PACKET, 1'b1, sb.magic, seq, len));
	endtask

	task automatic send_cmd(input logic [1:0] cmd);
		send_item(make_item(cmd, 1'b0, 32'h0, 32'h0, 16'h0));
	endtask

	// Magic register: written only with nothing in flight.
	task automatic write_magic(input logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		sb.set_magic(value);
		magic_writes++;
	endtask

	task automatic drain();
		pkt_in.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Mostly well-formed streams following the current expectation, with
	// gaps, late packets, jumps around half range, bad headers and commands.
	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		logic [31:0] base;
		logic [15:0] len;
		base = sb.seq_known ? sb.next_seq : $urandom();
		len = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(1518, 60));
		pick = $urandom_range(999);
		if (pick < 20)
			it = make_item(CMD_START, 1'($urandom()), $urandom(), $urandom(), 16'($urandom()));
		else if (pick < 32)
			it = make_item(CMD_STOP, 1'($urandom()), $urandom(), $urandom(), 16'($urandom()));
		else if (pick < 140)
			it = make_item(CMD_TICK, 1'($urandom()), $urandom(), $urandom(), 16'($urandom()));
		else if (pick < 700)
			it = make_item(CMD_PACKET, 1'b1, sb.magic, base, len);
		else if (pick < 770)
			it = make_item(CMD_PACKET, 1'b1, sb.magic, base + $urandom_range(40, 1), len);
		else if (pick < 830)
			it = make_item(CMD_PACKET, 1'b1, sb.magic, base - $urandom_range(60, 1), len);
		else if (pick < 860)
			it = make_item(CMD_PACKET, 1'b1, sb.magic,
				base + 32'h7FFF_FFFF + $urandom_range(2), len);
		else if (pick < 890)
			it = make_item(CMD_PACKET, 1'b1, sb.magic, $urandom(), len);
		else if (pick < 950) begin
			// wrong magic, any header flag
			it = make_item(CMD_PACKET, 1'($urandom()), $urandom(), $urandom(), len);
			if (it.magic_word == sb.magic)
				it.magic_word[0] = ~it.magic_word[0];
		end else begin
			// short header, content is irrelevant
			it = make_item(CMD_PACKET, 1'b0, ($urandom_range(1) != 0) ? sb.magic : $urandom(),
				$urandom(), len);
		end
		return it;
	endfunction

	// Every transaction counts, ignored ones while disarmed included.
	task automatic run_random(input int unsigned count);
		int unsigned n;
		item_t       it;
		n = 0;
		while (n < count) begin
			it = random_item();
			send_item(it);
			n++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pkt_in.valid = 1'b0;
		pkt_in.cmd = CMD_PACKET;
		pkt_in.header_ok = 1'b0;
		pkt_in.magic_word = '0;
		pkt_in.sequence_number = '0;
		pkt_in.packet_length = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		send_idle_pct = 33;
		recv_idle_pct = 51;
		hold_cycles = 0;
		magic_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-ones magic, every command, wrap and half-range edges.
		write_magic(32'hFFFF_FFFF);
		send_packet(32'd10, 16'd100);             // disarmed packet: ignored
		send_cmd(CMD_TICK);                       // disarmed tick: ignored
		send_cmd(CMD_STOP);                       // stop while disarmed: no effect
		send_cmd(CMD_START);
		send_cmd(CMD_TICK);
		send_packet(32'hFFFF_FFFF, 16'hFFFF);     // first packet sets expectation, wraps to 0
		send_packet(32'h0, 16'h0);                // exact match
		send_packet(32'd5, 16'd64);               // gap of four
		send_packet(32'd3, 16'd64);               // late
		send_packet(32'h8000_0005, 16'd64);       // jump of 2^31 - 1: still a gap
		send_packet(32'd6, 16'd64);               // exactly 2^31 behind: late
		send_packet(32'h0000_0005, 16'd64);       // another 2^31 - 1 gap, lost count wraps
		send_packet(32'h8000_0005, 16'd64);
		send_item(make_item(CMD_PACKET, 1'b0, sb.magic, 32'h8000_0006, 16'd64)); // short header
		send_item(make_item(CMD_PACKET, 1'b1, sb.magic ^ 32'h1, 32'h8000_0006, 16'd64));
		send_item(make_item(CMD_PACKET, 1'b0, 32'h0, 32'h0, 16'h0));
		send_cmd(CMD_TICK);
		send_cmd(CMD_START);                      // restart while armed clears everything
		send_packet(32'd100, 16'd1518);
		send_packet(32'd101, 16'd1);
		send_cmd(CMD_STOP);
		send_packet(32'd102, 16'd60);             // frozen counters
		send_cmd(CMD_TICK);
		send_cmd(CMD_START);
		drain();

		write_magic($urandom());
		run_random(610);
		drain();

		send_idle_pct = 51;
		recv_idle_pct = 33;
		write_magic(32'h0);
		run_random(610);
		drain();

		// No idling; first a long receiver hold-off while the sender keeps offering.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_magic($urandom());
		send_cmd(CMD_START);
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (40) send_packet(sb.seq_known ? sb.next_seq : 32'($urandom()), 16'd256);
		run_random(570);
		drain();
		repeat (8) @(posedge clk);

		sb.flush_leftover();
		$display("Covered %0d command transactions over %0d magic settings,",
			sb.items_noted, magic_writes);
		$display("including a stalled input; compared %0d results, %0d mismatches.",
			sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
